### rtl/core/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/scba_pkg.sv
// -----------------------------------------------------------------------------
// scba_pkg
// Word types, command and status codes and size-class tables for the
// size-class block allocator.
// -----------------------------------------------------------------------------
package scba_pkg;

	localparam int CMD_W         = 2;
	localparam int SIZE_W        = 17;
	localparam int STATUS_W      = 2;
	localparam int CLS_W         = 3;
	localparam int NUM_CLASS_MAX = 8;
	localparam int POS_W         = 32;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

	localparam logic [STATUS_W-1:0] STS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STS_NO_BLOCK   = 2'd1;
	localparam logic [STATUS_W-1:0] STS_BAD_OFFSET = 2'd2;
	localparam logic [STATUS_W-1:0] STS_FULL       = 2'd3;

	// log2 of the block size of each class: 64 B up to 16 KiB
	localparam logic [NUM_CLASS_MAX-1:0][3:0] CLASS_SHIFT = {
		4'd14, 4'd13, 4'd12, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6
	};

	// pool size taken when initialise is given zero bytes
	localparam logic [POS_W-1:0] FULL_POOL = 32'h4000_0000;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SIZE_W-1:0] size_bytes;
		logic [SIZE_W-1:0] free_offset;
	} req_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SIZE_W-1:0]   block_offset;
		logic [CLS_W-1:0]    size_class;
	} rsp_word_t;

	// decoded request, passed from the decoder to the control logic
	typedef struct packed {
		logic             fits;
		logic             free_ok;
		logic [CLS_W-1:0] cls;
	} dec_t;

	// byte position of the first block of every class
	function automatic logic [NUM_CLASS_MAX-1:0][POS_W-1:0] base_table(input int blocks);
		logic [NUM_CLASS_MAX-1:0][POS_W-1:0] tbl;
		logic [POS_W-1:0]                    acc;
		acc = '0;
		for (int i = 0; i < NUM_CLASS_MAX; i++) begin
			tbl[i] = acc;
			acc    = acc + (POS_W'(blocks) << CLASS_SHIFT[i]);
		end
		return tbl;
	endfunction

endpackage

### rtl/core/scba_decode.sv
// -----------------------------------------------------------------------------
// scba_decode
// Picks the size class of a request and decodes class and block index
// from a freed offset.
// -----------------------------------------------------------------------------
module scba_decode #(
	parameter int NUM_CLASSES      = 6,
	parameter int BLOCKS_PER_CLASS = 16,
	localparam int IDX_W = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1,
	localparam int CNT_W = $clog2(BLOCKS_PER_CLASS + 1)
) (
	input  scba_pkg::req_word_t                 word,
	input  logic [NUM_CLASSES-1:0][CNT_W-1:0]   built_count,
	output scba_pkg::dec_t                      dec,
	output logic [IDX_W-1:0]                    free_idx
);

	localparam logic [scba_pkg::NUM_CLASS_MAX-1:0][scba_pkg::POS_W-1:0] BASE =
		scba_pkg::base_table(BLOCKS_PER_CLASS);

	logic                           a_fit;
	logic [scba_pkg::CLS_W-1:0]     a_cls;
	logic                           f_ok;
	logic [scba_pkg::CLS_W-1:0]     f_cls;
	logic [scba_pkg::POS_W-1:0]     off;
	logic [scba_pkg::POS_W-1:0]     rel;
	logic [scba_pkg::POS_W-1:0]     span;
	logic [scba_pkg::POS_W-1:0]     blk;

	// smallest class holding the request: scan downwards, last hit wins
	always_comb begin
		a_fit = 1'b0;
		a_cls = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (scba_pkg::POS_W'(word.size_bytes) <=
					(scba_pkg::POS_W'(1) << scba_pkg::CLASS_SHIFT[c])) begin
				a_fit = 1'b1;
				a_cls = scba_pkg::CLS_W'(c);
			end
		end
	end

	// class ranges are disjoint, so at most one class claims the offset
	always_comb begin
		f_ok     = 1'b0;
		f_cls    = '0;
		free_idx = '0;
		off      = scba_pkg::POS_W'(word.free_offset);
		rel      = '0;
		span     = '0;
		blk      = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			rel  = off - BASE[c];
			span = scba_pkg::POS_W'(BLOCKS_PER_CLASS) << scba_pkg::CLASS_SHIFT[c];
			blk  = rel >> scba_pkg::CLASS_SHIFT[c];
			if (off >= BASE[c] && rel < span &&
					(rel & ((scba_pkg::POS_W'(1) << scba_pkg::CLASS_SHIFT[c]) -
						scba_pkg::POS_W'(1))) == '0 &&
					blk < scba_pkg::POS_W'(built_count[c])) begin
				f_ok     = 1'b1;
				f_cls    = scba_pkg::CLS_W'(c);
				free_idx = blk[IDX_W-1:0];
			end
		end
	end

	always_comb begin
		dec.fits    = a_fit;
		dec.free_ok = f_ok;
		dec.cls     = (word.cmd == scba_pkg::CMD_FREE) ? f_cls : a_cls;
	end

endmodule

### rtl/core/scba_stack_mem.sv
// -----------------------------------------------------------------------------
// scba_stack_mem
// Free-stack memory with registered read and per-entry written
// flags; an entry never written since the last clear reads as a miss.
// -----------------------------------------------------------------------------
module scba_stack_mem #(
	parameter int DEPTH  = 96,
	parameter int DATA_W = 4,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	output logic              rd_hit,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              clr
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [DEPTH-1:0]  vld_q;
	logic              rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// clear every flag at once on reset and initialise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;
	assign rd_hit  = rd_hit_q;

endmodule

### rtl/core/size_class_block_allocator.sv
// -----------------------------------------------------------------------------
// size_class_block_allocator
// Pool of fixed blocks in power-of-two size classes with one LIFO free
// stack per class; allocate, free and initialise commands.
// -----------------------------------------------------------------------------
// Usage:
//   Request words arrive on req_valid / req_stall / req_word, one result word
//   per request leaves on rsp_valid / rsp_stall / rsp_word. A word moves at a
//   rising edge with valid high and stall low.
//   Every command is decoded at the accept edge, which for an allocate also
//   reads the class's top-of-stack entry from the stack memory; the execute
//   state then writes the stack entry and counters back and loads the result
//   register once that register is free. A new request is taken only after
//   the previous one has left the execute state.
//   Initialise takes the same path: written flags on every stack entry
//   are cleared together and untouched entries read as their own depth.
//   Reset leaves the pool as after initialising the full pool, with no
//   clearing pass; the first request may be taken right after reset.
//   A stalled result is held in the output register; the next request is
//   still taken and waits in its execute cycle until the register frees.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module size_class_block_allocator #(
	parameter int NUM_CLASSES      = 6,
	parameter int BLOCKS_PER_CLASS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  scba_pkg::req_word_t req_word,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output scba_pkg::rsp_word_t rsp_word
);

	localparam int IDX_W  = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
	localparam int CNT_W  = $clog2(BLOCKS_PER_CLASS + 1);
	localparam int CI_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int DEPTH  = NUM_CLASSES * BLOCKS_PER_CLASS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W  = scba_pkg::POS_W;

	localparam logic [scba_pkg::NUM_CLASS_MAX-1:0][POS_W-1:0] BASE =
		scba_pkg::base_table(BLOCKS_PER_CLASS);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic [NUM_CLASSES-1:0][CNT_W-1:0] free_count_q;
	logic [NUM_CLASSES-1:0][CNT_W-1:0] built_count_q;
	logic [NUM_CLASSES-1:0][CNT_W-1:0] init_cnt;

	scba_pkg::dec_t       dec;
	logic [IDX_W-1:0]     free_idx;
	logic                 accept;
	logic [CI_W-1:0]      cls_a;
	logic [CNT_W-1:0]     top_cnt;
	logic                 rd_en;
	logic [ADDR_W-1:0]    rd_addr;
	logic [IDX_W-1:0]     rd_data;
	logic                 rd_hit;

	// stage 1: decoded request held through the execute cycle
	logic [scba_pkg::CMD_W-1:0]  cmd_s1;
	logic [scba_pkg::SIZE_W-1:0] size_s1;
	logic [scba_pkg::CLS_W-1:0]  cls_s1;
	logic                        fits_s1;
	logic                        free_ok_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [IDX_W-1:0]            top_s1;
	logic                        empty_s1;

	logic                 out_free;
	logic                 commit;
	logic [CI_W-1:0]      cls_e;
	logic [CNT_W-1:0]     cur_cnt;
	logic [CNT_W-1:0]     cur_blt;
	logic [IDX_W-1:0]     blk_idx;
	logic [POS_W-1:0]     blk_pos;
	logic                 cnt_dec;
	logic                 cnt_inc;
	logic                 do_init;
	logic                 mem_wr;
	logic [ADDR_W-1:0]    wr_addr;
	logic [POS_W-1:0]     pool;
	logic [POS_W-1:0]     fit_n;
	scba_pkg::rsp_word_t  res;

	logic                 rsp_valid_q;
	scba_pkg::rsp_word_t  rsp_word_q;

	// ---------------------------------------------------------------------
	// Accept: decode the word, fetch the top-of-stack entry for an allocate
	// ---------------------------------------------------------------------
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	scba_decode #(
		.NUM_CLASSES      (NUM_CLASSES),
		.BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
	) u_decode (
		.word        (req_word),
		.built_count (built_count_q),
		.dec         (dec),
		.free_idx    (free_idx)
	);

	assign cls_a   = dec.cls[CI_W-1:0];
	assign top_cnt = free_count_q[cls_a];
	assign rd_en   = accept && req_word.cmd == scba_pkg::CMD_ALLOC && dec.fits &&
		top_cnt != '0;
	assign rd_addr = ADDR_W'(cls_a * BLOCKS_PER_CLASS) + ADDR_W'(top_cnt - CNT_W'(1));

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= req_word.cmd;
			size_s1    <= req_word.size_bytes;
			cls_s1     <= dec.cls;
			fits_s1    <= dec.fits;
			free_ok_s1 <= dec.free_ok;
			idx_s1     <= free_idx;
			top_s1     <= IDX_W'(top_cnt - CNT_W'(1));
			empty_s1   <= (top_cnt == '0);
		end
	end

	scba_stack_mem #(
		.DEPTH  (DEPTH),
		.DATA_W (IDX_W)
	) u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rd_hit  (rd_hit),
		.wr_en   (mem_wr),
		.wr_addr (wr_addr),
		.wr_data (idx_s1),
		.clr     (do_init)
	);

	// ---------------------------------------------------------------------
	// Execute: form the result, write back stack and counters
	// ---------------------------------------------------------------------
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign commit   = (state_q == ST_EXEC) && out_free;

	always_comb begin
		res     = '0;
		cnt_dec = 1'b0;
		cnt_inc = 1'b0;
		do_init = 1'b0;
		mem_wr  = 1'b0;
		cls_e   = cls_s1[CI_W-1:0];
		cur_cnt = free_count_q[cls_e];
		cur_blt = built_count_q[cls_e];
		wr_addr = ADDR_W'(cls_e * BLOCKS_PER_CLASS) + ADDR_W'(cur_cnt);
		// an entry untouched since initialise holds its own depth
		blk_idx = rd_hit ? rd_data : top_s1;
		blk_pos = BASE[cls_s1] + (POS_W'(blk_idx) << scba_pkg::CLASS_SHIFT[cls_s1]);
		case (cmd_s1)
			scba_pkg::CMD_ALLOC: begin
				if (!fits_s1) begin
					res.status = scba_pkg::STS_NO_BLOCK;
				end else begin
					res.size_class = cls_s1;
					if (empty_s1) begin
						res.status = scba_pkg::STS_NO_BLOCK;
					end else begin
						res.block_offset = blk_pos[scba_pkg::SIZE_W-1:0];
						cnt_dec          = commit;
					end
				end
			end
			scba_pkg::CMD_FREE: begin
				if (!free_ok_s1) begin
					res.status = scba_pkg::STS_BAD_OFFSET;
				end else begin
					res.size_class = cls_s1;
					if (cur_cnt >= cur_blt) begin
						res.status = scba_pkg::STS_FULL;
					end else begin
						cnt_inc = commit;
						mem_wr  = commit;
					end
				end
			end
			scba_pkg::CMD_INIT: begin
				do_init = commit;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// blocks of each class that end within the pool; classes past the first
	// partial one start beyond the pool and count zero
	always_comb begin
		pool  = (size_s1 == '0) ? scba_pkg::FULL_POOL : POS_W'(size_s1);
		fit_n = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			fit_n = (pool - BASE[c]) >> scba_pkg::CLASS_SHIFT[c];
			if (pool < BASE[c] + (POS_W'(1) << scba_pkg::CLASS_SHIFT[c])) begin
				init_cnt[c] = '0;
			end else if (fit_n >= POS_W'(BLOCKS_PER_CLASS)) begin
				init_cnt[c] = CNT_W'(BLOCKS_PER_CLASS);
			end else begin
				init_cnt[c] = fit_n[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				free_count_q[c]  <= CNT_W'(BLOCKS_PER_CLASS);
				built_count_q[c] <= CNT_W'(BLOCKS_PER_CLASS);
			end
		end else if (do_init) begin
			free_count_q  <= init_cnt;
			built_count_q <= init_cnt;
		end else if (cnt_dec) begin
			free_count_q[cls_e] <= cur_cnt - CNT_W'(1);
		end else if (cnt_inc) begin
			free_count_q[cls_e] <= cur_cnt + CNT_W'(1);
		end
	end

	// advance to execute on accept, drop back to idle once the result lands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Output register: hold the word while the receiver stalls
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_word_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	`ASSERT_IMP(a_no_rd_wr_clash, clk, arst_n, rd_en, !mem_wr)
	`ASSERT_NXT(a_exec_lands, clk, arst_n, state_q == ST_EXEC && !rsp_valid_q,
		state_q == ST_IDLE && rsp_valid_q)
	`ASSERT_IMP(a_free_within_built, clk, arst_n, state_q == ST_EXEC,
		free_count_q[cls_e] <= built_count_q[cls_e])

endmodule

### test/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the size-class block allocator. Request words go
// in through a valid/stall sender and a predictor works out the result word
// of each accepted request. The result words coming back are checked in
// order against those predictions. Directed corner cases come first, then
// random alloc/free/init traffic, with some unused command codes, under
// three pacing mixes, then a long result hold-off that backs the block up.
// -----------------------------------------------------------------------------
module tb_top;

	localparam int NCLS = 6;
	localparam int NBLK = 16;
	localparam int SIZE_W = scba_pkg::SIZE_W;
	localparam int CLS_W  = scba_pkg::CLS_W;
	localparam int unsigned BLK_BYTES [NCLS] = '{64, 128, 256, 512, 1024, 4096};
	localparam longint unsigned WHOLE_POOL = 64'd1 << 30;
	localparam logic [scba_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	scba_pkg::req_word_t req_word = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	scba_pkg::rsp_word_t rsp_word;

	// pacing knobs, percent of cycles spent idle on each side
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_cycles = 0;
	int mismatch_cnt = 0;

	// predicted allocator state
	logic [3:0]  stk_entry [NCLS][NBLK];
	int unsigned free_cnt [NCLS];
	int unsigned built_cnt [NCLS];
	logic [SIZE_W-1:0]   held_blocks[$];
	scba_pkg::rsp_word_t owed_results[$];

	size_class_block_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_word (req_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word (rsp_word)
	);

	always #5 clk = ~clk;

	// byte position of the first block of class c; classes sit back to back
	function automatic longint unsigned class_start(int c);
		longint unsigned acc;
		acc = 0;
		for (int i = 0; i < c; i++)
			acc += longint'(NBLK) * BLK_BYTES[i];
		return acc;
	endfunction

	// rebuild every stack, keeping only blocks that end inside the pool
	function automatic void rebuild_pool(longint unsigned pool);
		longint unsigned pos;
		int n;
		pos = 0;
		for (int c = 0; c < NCLS; c++) begin
			n = 0;
			for (int j = 0; j < NBLK; j++) begin
				// once one block misses, every later one misses too
				if (n == j && pos + BLK_BYTES[c] <= pool) begin
					stk_entry[c][j] = 4'(j);
					pos += BLK_BYTES[c];
					n++;
				end else begin
					stk_entry[c][j] = '0;
				end
			end
			free_cnt[c]  = n;
			built_cnt[c] = n;
		end
		held_blocks.delete();
	endfunction

	// advance the predicted state by one request and return its result word
	function automatic scba_pkg::rsp_word_t predict_alloc_result(scba_pkg::req_word_t w);
		scba_pkg::rsp_word_t r;
		int pick;
		bit hit;
		longint unsigned base, rel, blk;
		r    = '0;
		pick = -1;
		hit  = 1'b0;
		blk  = 0;
		case (w.cmd)
			scba_pkg::CMD_ALLOC: begin
				// smallest class that holds the request; zero bytes lands in class 0
				for (int c = NCLS - 1; c >= 0; c--)
					if (w.size_bytes <= BLK_BYTES[c])
						pick = c;
				if (pick < 0) begin
					r.status = scba_pkg::STS_NO_BLOCK;
				end else begin
					r.size_class = CLS_W'(pick);
					if (free_cnt[pick] == 0) begin
						r.status = scba_pkg::STS_NO_BLOCK;
					end else begin
						free_cnt[pick]--;
						r.block_offset = SIZE_W'(class_start(pick) +
							longint'(stk_entry[pick][free_cnt[pick]]) * BLK_BYTES[pick]);
						held_blocks.push_back(r.block_offset);
					end
				end
			end
			scba_pkg::CMD_FREE: begin
				for (int c = 0; c < NCLS; c++) begin
					base = class_start(c);
					if (!hit && w.free_offset >= base &&
							w.free_offset < base + longint'(NBLK) * BLK_BYTES[c]) begin
						hit = 1'b1;
						rel = w.free_offset - base;
						blk = rel / BLK_BYTES[c];
						if (rel % BLK_BYTES[c] == 0 && blk < built_cnt[c])
							pick = c;
					end
				end
				if (pick < 0) begin
					r.status = scba_pkg::STS_BAD_OFFSET;
				end else begin
					r.size_class = CLS_W'(pick);
					if (free_cnt[pick] >= built_cnt[pick]) begin
						r.status = scba_pkg::STS_FULL;
					end else begin
						// double frees go through while there is room
						stk_entry[pick][free_cnt[pick]] = 4'(blk);
						free_cnt[pick]++;
					end
				end
			end
			scba_pkg::CMD_INIT:
				rebuild_pool(w.size_bytes == 0 ? WHOLE_POOL : longint'(w.size_bytes));
			default: ;
		endcase
		return r;
	endfunction

	// random request, mostly frees of blocks we hold and allocs of any class
	function automatic scba_pkg::req_word_t pick_request();
		scba_pkg::req_word_t w;
		int roll, c, idx;
		w.cmd         = scba_pkg::CMD_ALLOC;
		w.size_bytes  = SIZE_W'($urandom);
		w.free_offset = SIZE_W'($urandom);
		roll = $urandom_range(99);
		if (roll < 45) begin
			c = $urandom_range(NCLS - 1);
			if ($urandom_range(19) == 0)
				w.size_bytes = SIZE_W'($urandom_range(131071, 4097));
			else
				w.size_bytes = SIZE_W'($urandom_range(BLK_BYTES[c],
					c == 0 ? 0 : BLK_BYTES[c - 1] + 1));
		end else if (roll < 85 && held_blocks.size() > 0) begin
			w.cmd = scba_pkg::CMD_FREE;
			idx = $urandom_range(held_blocks.size() - 1);
			w.free_offset = held_blocks[idx];
			// keep one in ten on the list so it gets freed twice
			if ($urandom_range(9) != 0)
				held_blocks.delete(idx);
		end else if (roll < 90) begin
			w.cmd = scba_pkg::CMD_FREE;
			if ($urandom_range(1) == 0)
				w.free_offset = SIZE_W'($urandom_range(97279)) & ~SIZE_W'(63);
		end else if (roll < 95) begin
			w.cmd = scba_pkg::CMD_INIT;
			case ($urandom_range(3))
				0: w.size_bytes = '0;
				1: ;
				2: w.size_bytes = SIZE_W'($urandom_range(97280));
				default: w.size_bytes = SIZE_W'($urandom_range(4095));
			endcase
		end else begin
			w.cmd = CMD_UNUSED;
		end
		return w;
	endfunction

	// offer one word and hold it until the block takes it; valid is left high
	// so a following word goes out back to back
	task automatic send_word(scba_pkg::req_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		do @(posedge clk); while (req_stall);
		owed_results.push_back(predict_alloc_result(w));
	endtask

	task automatic send_req(logic [scba_pkg::CMD_W-1:0] cmd, int unsigned size,
			int unsigned off);
		scba_pkg::req_word_t w;
		w.cmd         = cmd;
		w.size_bytes  = SIZE_W'(size);
		w.free_offset = SIZE_W'(off);
		send_word(w);
	endtask

	// receiver pacing; a hold-off, when set, overrides the random stalls
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			rx_hold_cycles--;
		end else begin
			rsp_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// check every result word taken against the oldest prediction
	always @(posedge clk) begin : result_check
		scba_pkg::rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_results.size() == 0) begin
				$display("%0t: unexpected result: status %0d offset %0d class %0d",
					$time, rsp_word.status, rsp_word.block_offset,
					rsp_word.size_class);
				mismatch_cnt++;
			end else begin
				want = owed_results.pop_front();
				if (rsp_word.status !== want.status ||
						rsp_word.block_offset !== want.block_offset ||
						rsp_word.size_class !== want.size_class) begin
					$display("%0t: mismatch: expected status %0d offset %0d class %0d,",
						$time, want.status, want.block_offset, want.size_class,
						" got status %0d offset %0d class %0d",
						rsp_word.status, rsp_word.block_offset, rsp_word.size_class);
					mismatch_cnt++;
				end
			end
		end
	end

	// corner cases, starting from the full pool left by reset
	task automatic test_directed();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_req(scba_pkg::CMD_ALLOC, 0, 0);           // zero bytes served from class 0
		send_req(scba_pkg::CMD_ALLOC, 64, 0);          // exact fit at top of class 0
		send_req(scba_pkg::CMD_ALLOC, 65, 0);          // one byte over pushes to class 1
		send_req(scba_pkg::CMD_ALLOC, 4096, 0);        // largest class
		send_req(scba_pkg::CMD_ALLOC, 4097, 0);        // larger than every class
		send_req(scba_pkg::CMD_ALLOC, 131071, 131071);
		send_req(scba_pkg::CMD_FREE, 0, 960);
		send_req(scba_pkg::CMD_FREE, 0, 896);
		send_req(scba_pkg::CMD_FREE, 0, 0);            // class 0 stack full again
		send_req(scba_pkg::CMD_ALLOC, 128, 0);
		send_req(scba_pkg::CMD_FREE, 0, 2944);
		send_req(scba_pkg::CMD_FREE, 0, 2944);         // double free with room left
		send_req(scba_pkg::CMD_FREE, 0, 2816);         // now the class is full
		send_req(scba_pkg::CMD_FREE, 0, 1);            // off a block boundary
		send_req(scba_pkg::CMD_FREE, 0, 97280);        // just past the last class
		send_req(scba_pkg::CMD_FREE, 131071, 131071);
		send_req(CMD_UNUSED, 131071, 131071);
		send_req(scba_pkg::CMD_INIT, 100, 0);          // one class 0 block only
		send_req(scba_pkg::CMD_ALLOC, 1, 0);
		send_req(scba_pkg::CMD_ALLOC, 64, 0);          // class 0 empty
		send_req(scba_pkg::CMD_FREE, 0, 64);           // block never built
		send_req(scba_pkg::CMD_ALLOC, 200, 0);         // class 2 has nothing built
		send_req(scba_pkg::CMD_FREE, 0, 0);
		send_req(scba_pkg::CMD_INIT, 131071, 0);
		send_req(scba_pkg::CMD_INIT, 0, 0);
	endtask

	task automatic test_random_mix(int tx_pct, int rx_pct, int n_words);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (n_words)
			send_word(pick_request());
	endtask

	// hold the result side off for a long stretch while requests keep coming
	task automatic test_backpressure();
		tx_idle_pct    = 0;
		rx_idle_pct    = 0;
		rx_hold_cycles = 200;
		repeat (16)
			send_word(pick_request());
	endtask

	task automatic wait_results_drained();
		int waited;
		waited = 0;
		while (owed_results.size() > 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		if (owed_results.size() > 0) begin
			$display("%0t: %0d results never arrived", $time, owed_results.size());
			mismatch_cnt++;
		end
	endtask

	initial begin
		rebuild_pool(WHOLE_POOL);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_mix(20, 59, 250);
		test_random_mix(59, 20, 250);
		test_random_mix(0, 0, 250);
		test_backpressure();

		// drop valid once the last word is in, then drain
		@(negedge clk);
		req_valid <= 1'b0;
		wait_results_drained();
		repeat (20) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
